// ===== hdl/bplp_pkg.sv =====
package bplp_pkg;

    localparam int unsigned CFG_COUNT   = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned PADDR_W     = CFG_IDX_W + 2;

    // Fixed widths of the fields and counters.
    localparam int unsigned DEB_W       = 8;
    localparam int unsigned REL_W       = 8;
    localparam int unsigned HOLD_W      = 10;
    localparam int unsigned PROG_W      = 10;
    localparam int unsigned TOG_W       = 3;

    localparam logic [PROG_W-1:0] SIGNAL_PERIOD  = 10'd100;
    localparam logic [TOG_W-1:0]  SIGNAL_TOGGLES = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_PICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PAT_OFF     = 3'd0,
        PAT_GLOW    = 3'd1,
        PAT_STARTUP = 3'd2,
        PAT_SHORT   = 3'd3,
        PAT_FAST    = 3'd4,
        PAT_SLOW    = 3'd5,
        PAT_SIGNAL  = 3'd6
    } pattern_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_NORMAL = 2'd1,
        EV_LONG   = 2'd2
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_ENABLE  = 3'd0,
        REG_DEBOUNCE_TICKS = 3'd1,
        REG_LONG_PRESS     = 3'd2,
        REG_RELEASE_TMO    = 3'd3,
        REG_SLOW_PERIOD    = 3'd4,
        REG_FAST_PERIOD    = 3'd5,
        REG_STARTUP_DUR    = 3'd6,
        REG_SHORT_DUR      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic              detect_enable;
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
        logic [REL_W-1:0]  release_timeout_ticks;
        logic [PROG_W-1:0] slow_blink_period;
        logic [PROG_W-1:0] fast_blink_period;
        logic [PROG_W-1:0] startup_duration;
        logic [PROG_W-1:0] short_blink_duration;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        detect_enable:         1'b1,
        debounce_ticks:        8'd2,
        long_press_ticks:      10'd500,
        release_timeout_ticks: 8'd100,
        slow_blink_period:     10'd80,
        fast_blink_period:     10'd20,
        startup_duration:      10'd300,
        short_blink_duration:  10'd10
    };

    // Saturating increments; each counter stops at its all-ones value.
    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [9:0] sat_inc10(input logic [9:0] v);
        return (v == 10'h3FF) ? v : v + 10'd1;
    endfunction

    function automatic logic [2:0] sat_inc3(input logic [2:0] v);
        return (v == 3'h7) ? v : v + 3'd1;
    endfunction

endpackage

// ===== hdl/bplp_cfg.sv =====
module bplp_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bplp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output bplp_pkg::cfg_t               cfg
);

    bplp_pkg::cfg_t     cfg_reg;
    bplp_pkg::cfg_t     cfg_next;
    bplp_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = bplp_pkg::reg_idx_t'(paddr[bplp_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                bplp_pkg::REG_DETECT_ENABLE:  cfg_next.detect_enable = pwdata[0];
                bplp_pkg::REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = pwdata[7:0];
                bplp_pkg::REG_LONG_PRESS:     cfg_next.long_press_ticks = pwdata[9:0];
                bplp_pkg::REG_RELEASE_TMO:    cfg_next.release_timeout_ticks = pwdata[7:0];
                bplp_pkg::REG_SLOW_PERIOD:    cfg_next.slow_blink_period = pwdata[9:0];
                bplp_pkg::REG_FAST_PERIOD:    cfg_next.fast_blink_period = pwdata[9:0];
                bplp_pkg::REG_STARTUP_DUR:    cfg_next.startup_duration = pwdata[9:0];
                bplp_pkg::REG_SHORT_DUR:      cfg_next.short_blink_duration = pwdata[9:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bplp_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            bplp_pkg::REG_DETECT_ENABLE:  prdata = {31'd0, cfg_reg.detect_enable};
            bplp_pkg::REG_DEBOUNCE_TICKS: prdata = {24'd0, cfg_reg.debounce_ticks};
            bplp_pkg::REG_LONG_PRESS:     prdata = {22'd0, cfg_reg.long_press_ticks};
            bplp_pkg::REG_RELEASE_TMO:    prdata = {24'd0, cfg_reg.release_timeout_ticks};
            bplp_pkg::REG_SLOW_PERIOD:    prdata = {22'd0, cfg_reg.slow_blink_period};
            bplp_pkg::REG_FAST_PERIOD:    prdata = {22'd0, cfg_reg.fast_blink_period};
            bplp_pkg::REG_STARTUP_DUR:    prdata = {22'd0, cfg_reg.startup_duration};
            bplp_pkg::REG_SHORT_DUR:      prdata = {22'd0, cfg_reg.short_blink_duration};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/bplp_core.sv =====
module bplp_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  logic [1:0]     cmd,
    input  logic           button_level,
    input  logic [2:0]     pattern,
    input  bplp_pkg::cfg_t cfg,
    output logic [1:0]     button_event,
    output logic           led_on
);

    logic                            deb_active_reg, deb_active_next;
    logic [bplp_pkg::DEB_W-1:0]      deb_count_reg, deb_count_next;
    logic                            pending_reg, pending_next;
    logic [bplp_pkg::REL_W-1:0]      rel_count_reg, rel_count_next;
    logic [bplp_pkg::HOLD_W-1:0]     hold_count_reg, hold_count_next;
    bplp_pkg::pattern_t              mode_reg, mode_next;
    logic [bplp_pkg::PROG_W-1:0]     progress_reg, progress_next;
    logic [bplp_pkg::TOG_W-1:0]      toggles_reg, toggles_next;
    logic                            led_reg, led_next;
    bplp_pkg::event_t                ev;
    bplp_pkg::pattern_t              pick;
    logic [bplp_pkg::PROG_W-1:0]     prog_inc;
    logic [bplp_pkg::TOG_W-1:0]      tog_inc;
    logic [bplp_pkg::PROG_W-1:0]     limit;

    assign pick     = bplp_pkg::pattern_t'(pattern);
    assign prog_inc = bplp_pkg::sat_inc10(progress_reg);
    assign tog_inc  = bplp_pkg::sat_inc3(toggles_reg);

    // Period or duration that the current pattern counts toward.
    always_comb begin
        case (mode_reg)
            bplp_pkg::PAT_SLOW:    limit = cfg.slow_blink_period;
            bplp_pkg::PAT_FAST:    limit = cfg.fast_blink_period;
            bplp_pkg::PAT_STARTUP: limit = cfg.startup_duration;
            bplp_pkg::PAT_SHORT:   limit = cfg.short_blink_duration;
            default:               limit = bplp_pkg::SIGNAL_PERIOD;
        endcase
    end

    always_comb begin
        deb_active_next = deb_active_reg;
        deb_count_next  = deb_count_reg;
        pending_next    = pending_reg;
        rel_count_next  = rel_count_reg;
        hold_count_next = hold_count_reg;
        mode_next       = mode_reg;
        progress_next   = progress_reg;
        toggles_next    = toggles_reg;
        led_next        = led_reg;
        ev              = bplp_pkg::EV_NONE;

        case (bplp_pkg::cmd_t'(cmd))
            bplp_pkg::CMD_TICK: begin
                if (deb_active_reg) begin
                    deb_count_next = bplp_pkg::sat_inc8(deb_count_reg);
                    if (deb_count_next >= cfg.debounce_ticks) begin
                        deb_active_next = 1'b0;
                    end
                end

                if (pending_reg) begin
                    if (!button_level) begin
                        hold_count_next = bplp_pkg::sat_inc10(hold_count_reg);
                        if (hold_count_next >= cfg.long_press_ticks) begin
                            ev              = bplp_pkg::EV_LONG;
                            pending_next    = 1'b0;
                            rel_count_next  = '0;
                            hold_count_next = '0;
                        end
                    end else begin
                        rel_count_next = bplp_pkg::sat_inc8(rel_count_reg);
                        if (rel_count_next >= cfg.release_timeout_ticks) begin
                            ev              = bplp_pkg::EV_NORMAL;
                            pending_next    = 1'b0;
                            rel_count_next  = '0;
                            hold_count_next = '0;
                        end
                    end
                end

                case (mode_reg)
                    bplp_pkg::PAT_SLOW, bplp_pkg::PAT_FAST: begin
                        progress_next = prog_inc;
                        if (prog_inc >= limit) begin
                            led_next      = ~led_reg;
                            progress_next = '0;
                        end
                    end
                    bplp_pkg::PAT_STARTUP, bplp_pkg::PAT_SHORT: begin
                        progress_next = prog_inc;
                        if (prog_inc >= limit) begin
                            mode_next     = bplp_pkg::PAT_OFF;
                            progress_next = '0;
                            toggles_next  = '0;
                        end
                    end
                    bplp_pkg::PAT_SIGNAL: begin
                        progress_next = prog_inc;
                        if (prog_inc >= limit) begin
                            led_next      = ~led_reg;
                            progress_next = '0;
                            toggles_next  = tog_inc;
                            if (tog_inc >= bplp_pkg::SIGNAL_TOGGLES) begin
                                mode_next    = bplp_pkg::PAT_OFF;
                                toggles_next = '0;
                            end
                        end
                    end
                    default: begin
                        progress_next = progress_reg;
                    end
                endcase

                if (mode_next == bplp_pkg::PAT_OFF && button_level) begin
                    led_next = 1'b0;
                end
            end

            bplp_pkg::CMD_EDGE: begin
                if (cfg.detect_enable && !deb_active_reg) begin
                    if (!button_level) begin
                        led_next       = 1'b1;
                        pending_next   = 1'b1;
                        rel_count_next = '0;
                    end else begin
                        led_next        = 1'b0;
                        hold_count_next = '0;
                    end
                    deb_active_next = 1'b1;
                    deb_count_next  = '0;
                end
            end

            bplp_pkg::CMD_PICK: begin
                if (pattern != 3'd7) begin
                    mode_next     = pick;
                    progress_next = '0;
                    toggles_next  = '0;
                    if (pick inside {bplp_pkg::PAT_GLOW, bplp_pkg::PAT_STARTUP,
                                     bplp_pkg::PAT_SHORT}) begin
                        led_next = 1'b1;
                    end
                end
            end

            default: begin
                pending_next    = 1'b0;
                rel_count_next  = '0;
                hold_count_next = '0;
            end
        endcase
    end

    assign button_event = ev;
    assign led_on       = led_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_active_reg <= 1'b0;
            deb_count_reg  <= '0;
            pending_reg    <= 1'b0;
            rel_count_reg  <= '0;
            hold_count_reg <= '0;
            mode_reg       <= bplp_pkg::PAT_OFF;
            progress_reg   <= '0;
            toggles_reg    <= '0;
            led_reg        <= 1'b0;
        end else if (fire) begin
            deb_active_reg <= deb_active_next;
            deb_count_reg  <= deb_count_next;
            pending_reg    <= pending_next;
            rel_count_reg  <= rel_count_next;
            hold_count_reg <= hold_count_next;
            mode_reg       <= mode_next;
            progress_reg   <= progress_next;
            toggles_reg    <= toggles_next;
            led_reg        <= led_next;
        end
    end

endmodule

// ===== hdl/button_press_and_led_pattern_top.sv =====
// Button press classifier and status LED pattern generator. Each input transfer
// carries one command: a tick, a debounced pin-change sample of the active-low
// button, a pattern pick, or a clear of the press counters. Every input transfer
// yields exactly one result transfer holding the press event reported by that
// item (none, normal press, long press) and the LED level after it. The block
// takes one transfer per clock cycle when the result side keeps up; a result is
// offered on m_valid once its item has passed the input register and then the
// result register, which bracket the single pass of next-state logic. When the
// result side stalls, the two registers hold two items before s_ready drops.
// Configuration registers sit on an APB-style port at byte offsets 4*i and
// should only be written while no transfer is in flight.
module button_press_and_led_pattern_top (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Input channel.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic                         s_button_level,
    input  logic [2:0]                   s_pattern,

    // Result channel.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_button_event,
    output logic                         m_led_on,

    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bplp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    bplp_pkg::cfg_t cfg;

    // Input register.
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic       in_level_reg;
    logic [2:0] in_pattern_reg;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] out_event_reg;
    logic       out_led_reg;

    logic       out_free;
    logic       fire;
    logic [1:0] core_event;
    logic       core_led;

    // The result register can take a new value when it is empty or being
    // drained this cycle; the input register moves forward whenever it can.
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg     <= s_cmd;
            in_level_reg   <= s_button_level;
            in_pattern_reg <= s_pattern;
        end
    end

    bplp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // All pattern and press state lives in the core and advances on the edge that moves the
    // item into the result register, so the next item sees it at once.
    bplp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .cmd          (in_cmd_reg),
        .button_level (in_level_reg),
        .pattern      (in_pattern_reg),
        .cfg          (cfg),
        .button_event (core_event),
        .led_on       (core_led)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_event_reg <= core_event;
            out_led_reg   <= core_led;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_button_event = out_event_reg;
    assign m_led_on       = out_led_reg;

endmodule
